/* hw/rtl/dpf_pkg.sv */
// Shared constants, types and helper functions of the dark pixel fill block.
`default_nettype none

package dpf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = 2 * MAX_WIDTH + 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int IMAGE_WIDTH_RESET  = 1024;
    localparam int IMAGE_HEIGHT_RESET = 1024;

    localparam int NCH    = 3;
    localparam int CH_W   = 8;
    localparam int CH_MAX = (1 << CH_W) - 1;
    localparam int POS_W  = 10;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LIM_W  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                            $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int DIM_W  = ((LIM_W > CFG_W) ? LIM_W : CFG_W) + 1;
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);

    localparam int NB_COUNT  = 8;
    localparam int K_LIMIT   = 3;
    localparam int K_W       = $clog2(NB_COUNT + 1);
    localparam int SUM_W     = $clog2(NB_COUNT * CH_MAX + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    typedef logic [ADDR_W-1:0]              addr_t;
    typedef logic [ADDR_W:0]                addr_x_t;
    typedef logic [CFG_W-1:0]               cfg_t;
    typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
    typedef logic [DIM_W-1:0]               dim_t;
    typedef logic [PEND_W-1:0]              pend_t;
    typedef logic [COL_W-1:0]               col_t;
    typedef logic [ROW_W-1:0]               row_t;
    typedef logic [POS_W-1:0]               pos_t;
    typedef logic [CH_W-1:0]                ch_t;
    typedef logic [NCH-1:0][CH_W-1:0]       pix_t;
    typedef logic [K_W-1:0]                 k_t;
    typedef logic [SUM_W-1:0]               sum_t;
    typedef logic [NCH-1:0][SUM_W-1:0]      sums_t;
    typedef logic [NCH-1:0][K_W-1:0]        rems_t;
    typedef logic [DIV_CNT_W-1:0]           div_cnt_t;

    localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

    typedef struct packed {
        logic accept;
        logic rd_center;
        logic check;
        logic gather;
        logic div_start;
        logic div_step;
        logic write_back;
        logic finish;
    } dpf_cmd_t;

    typedef struct packed {
        logic emit_req;
        logic repair;
        logic gather_last;
        logic k_ok;
        logic div_done;
        logic out_free;
    } dpf_status_t;

    function automatic dim_t eff_dim(cfg_t v, dim_t limit);
        dim_t x;
        x = dim_t'(v);
        if (x == '0)
            x = dim_t'(1);
        else if (x > limit)
            x = limit;
        return x;
    endfunction

    function automatic addr_t sub_mod(addr_t a, addr_x_t b);
        addr_x_t d;
        d = addr_x_t'(a) - b;
        if (d[ADDR_W])
            d = d + addr_x_t'(STORE_DEPTH);
        return d[ADDR_W-1:0];
    endfunction

    function automatic addr_t add_mod(addr_t a, addr_t b);
        addr_x_t s;
        s = addr_x_t'(a) + addr_x_t'(b);
        if (s >= addr_x_t'(STORE_DEPTH))
            s = s - addr_x_t'(STORE_DEPTH);
        return s[ADDR_W-1:0];
    endfunction

    function automatic pos_t to_pos(logic [31:0] v);
        return v[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dpf_if.sv */
// Channel interfaces: pixel input, result output and configuration write.
`default_nettype none

interface dpf_in_if;
    import dpf_pkg::*;
    logic valid;
    logic ready;
    ch_t  red_in;
    ch_t  green_in;
    ch_t  blue_in;
    logic flush;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output flush, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input flush, output ready);
endinterface

interface dpf_out_if;
    import dpf_pkg::*;
    logic valid;
    logic ready;
    logic out_valid;
    ch_t  red_out;
    ch_t  green_out;
    ch_t  blue_out;
    pos_t out_column;
    pos_t out_row;
    logic frame_end;

    modport source (output valid, output out_valid, output red_out, output green_out,
                    output blue_out, output out_column, output out_row,
                    output frame_end, input ready);
    modport sink   (input valid, input out_valid, input red_out, input green_out,
                    input blue_out, input out_column, input out_row,
                    input frame_end, output ready);
endinterface

interface dpf_cfg_if;
    import dpf_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    cfg_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dpf_divider.sv */
// Radix-2 restoring divider, one quotient bit per cycle while step is asserted, for all three channels.
`default_nettype none

module dpf_divider (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            step,
    input  dpf_pkg::sums_t  dividend,
    input  dpf_pkg::k_t     divisor,
    output dpf_pkg::sums_t  quotient,
    output logic            done
);
    import dpf_pkg::*;

    div_cnt_t         count_reg;
    div_cnt_t         count_next;
    sums_t            quo_reg;
    sums_t            quo_next;
    rems_t            rem_reg;
    rems_t            rem_next;
    logic [K_W:0]     trial;

    assign done     = (count_reg == div_cnt_t'(SUM_W));
    assign quotient = quo_reg;

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        trial      = '0;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            count_next = '0;
        end
        else if (step && !done)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                trial = {rem_reg[c], quo_reg[c][SUM_W-1]};
                if (trial >= {1'b0, divisor})
                begin
                    rem_next[c] = k_t'(trial - {1'b0, divisor});
                    quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = trial[K_W-1:0];
                    quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b0};
                end
            end
            count_next = count_reg + div_cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/dpf_datapath.sv */
// Datapath: pixel store, position counters, 3x3 gather, divide and result register.
`default_nettype none

module dpf_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dpf_pkg::pix_t         pix_in,
    input  logic                  flush,
    input  dpf_pkg::dpf_cmd_t     cmd,
    output dpf_pkg::dpf_status_t  status,
    dpf_cfg_if.sink               cfg,
    dpf_out_if.source             results
);
    import dpf_pkg::*;

    typedef logic [1:0] nb_t;
    localparam nb_t NB_MID  = nb_t'(1);
    localparam nb_t NB_LAST = nb_t'(2);

    cfg_t   width_reg;
    cfg_t   height_reg;
    dim_t   w_eff;
    dim_t   h_eff;

    addr_t  wr_reg;
    pend_t  pending_reg;
    pend_t  total_reg;
    col_t   col_cnt_reg;
    col_t   col_cnt_next;
    row_t   row_cnt_reg;
    row_t   row_cnt_next;

    pix_t   store [STORE_DEPTH];
    pix_t   rd_data_reg;
    logic   mem_we;
    logic   mem_re;
    addr_t  mem_waddr;
    addr_t  mem_raddr;
    pix_t   mem_wdata;
    addr_t  rp_calc;

    addr_t  rp_reg;
    addr_t  row_base_reg;
    nb_t    nb_col_reg;
    nb_t    nb_row_reg;
    logic   acc_en_reg;
    sums_t  sum_reg;
    k_t     k_reg;

    pix_t   res_px_reg;
    logic   res_has_px_reg;

    logic   out_hold_reg;
    logic   out_valid_reg;
    pix_t   out_pix_reg;
    pos_t   out_col_reg;
    pos_t   out_row_reg;
    logic   frame_end_reg;

    sums_t  quotient;
    logic   div_done;
    pix_t   div_px;

    logic   col_last;
    logic   row_last;
    logic   interior;
    logic   dark;

    assign w_eff = eff_dim(width_reg, dim_t'(MAX_WIDTH));
    assign h_eff = eff_dim(height_reg, dim_t'(MAX_HEIGHT));

    assign col_last = (dim_t'(col_cnt_reg) + dim_t'(1)) >= w_eff;
    assign row_last = (dim_t'(row_cnt_reg) + dim_t'(1)) >= h_eff;
    assign interior = (row_cnt_reg != '0) && !row_last && (col_cnt_reg != '0) && !col_last &&
                      (dim_t'(total_reg) >= (w_eff + dim_t'(2)));

    always_comb
    begin
        dark = 1'b0;
        for (int c = 0; c < NCH; c++)
            if (rd_data_reg[c] == '0)
                dark = 1'b1;
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg + col_t'(1);
        row_cnt_next = row_cnt_reg;
        if (col_last)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_last ? '0 : row_cnt_reg + row_t'(1);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
            div_px[c] = (quotient[c] > sum_t'(CH_MAX)) ? ch_t'(CH_MAX) :
                        quotient[c][CH_W-1:0];
    end

    assign status.emit_req    = flush ? (pending_reg != '0) :
                                (dim_t'(pending_reg) >= (w_eff + dim_t'(1)));
    assign status.repair      = interior && dark;
    assign status.gather_last = (nb_row_reg == NB_LAST) && (nb_col_reg == NB_LAST);
    assign status.k_ok        = k_reg > k_t'(K_LIMIT);
    assign status.div_done    = div_done;
    assign status.out_free    = !out_hold_reg || results.ready;

    assign rp_calc   = sub_mod(wr_reg, addr_x_t'(total_reg));
    assign mem_we    = (cmd.accept && !flush) || cmd.write_back;
    assign mem_waddr = cmd.write_back ? rp_reg : wr_reg;
    assign mem_wdata = cmd.write_back ? div_px : pix_in;
    assign mem_re    = cmd.rd_center || cmd.gather;
    assign mem_raddr = cmd.gather ? add_mod(row_base_reg, addr_t'(nb_col_reg)) : rp_calc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= store[mem_raddr];
    end

    dpf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (sum_reg),
        .divisor  (k_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= cfg_t'(IMAGE_WIDTH_RESET);
            height_reg     <= cfg_t'(IMAGE_HEIGHT_RESET);
            wr_reg         <= '0;
            pending_reg    <= '0;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            acc_en_reg     <= 1'b0;
            res_has_px_reg <= 1'b0;
            out_hold_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                    default:          ;
                endcase
            end
            if (cmd.accept)
            begin
                if (!flush)
                    wr_reg <= add_mod(wr_reg, addr_t'(1));
                if (flush && status.emit_req)
                    pending_reg <= pending_reg - pend_t'(1);
                else if (!flush && !status.emit_req)
                    pending_reg <= pending_reg + pend_t'(1);
                res_has_px_reg <= status.emit_req;
            end
            acc_en_reg <= cmd.gather;
            if (cmd.finish)
            begin
                out_hold_reg <= 1'b1;
                if (res_has_px_reg)
                begin
                    col_cnt_reg <= col_cnt_next;
                    row_cnt_reg <= row_cnt_next;
                end
            end
            else if (results.ready)
                out_hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            total_reg <= flush ? pending_reg : pending_reg + pend_t'(1);
        if (cmd.rd_center)
            rp_reg <= rp_calc;
        if (cmd.check)
        begin
            res_px_reg   <= rd_data_reg;
            row_base_reg <= sub_mod(rp_reg, addr_x_t'(w_eff + dim_t'(1)));
            nb_col_reg   <= '0;
            nb_row_reg   <= '0;
            sum_reg      <= '0;
            k_reg        <= k_t'(NB_COUNT);
        end
        // skip the center position
        if (cmd.gather)
        begin
            if (nb_col_reg == NB_LAST)
            begin
                nb_col_reg   <= '0;
                nb_row_reg   <= nb_row_reg + nb_t'(1);
                row_base_reg <= add_mod(row_base_reg, addr_t'(w_eff));
            end
            else if ((nb_row_reg == NB_MID) && (nb_col_reg == '0))
                nb_col_reg <= NB_LAST;
            else
                nb_col_reg <= nb_col_reg + nb_t'(1);
        end
        if (acc_en_reg)
        begin
            for (int c = 0; c < NCH; c++)
                sum_reg[c] <= sum_reg[c] + sum_t'(rd_data_reg[c]);
            if (rd_data_reg == '0)
                k_reg <= k_reg - k_t'(1);
        end
        if (cmd.write_back)
            res_px_reg <= div_px;
        if (cmd.finish)
        begin
            out_valid_reg <= res_has_px_reg;
            out_pix_reg   <= res_has_px_reg ? res_px_reg : '0;
            out_col_reg   <= res_has_px_reg ? to_pos(32'(col_cnt_reg)) : '0;
            out_row_reg   <= res_has_px_reg ? to_pos(32'(row_cnt_reg)) : '0;
            frame_end_reg <= res_has_px_reg && col_last && row_last;
        end
    end

    assign results.valid      = out_hold_reg;
    assign results.out_valid  = out_valid_reg;
    assign results.red_out    = out_pix_reg[2];
    assign results.green_out  = out_pix_reg[1];
    assign results.blue_out   = out_pix_reg[0];
    assign results.out_column = out_col_reg;
    assign results.out_row    = out_row_reg;
    assign results.frame_end  = frame_end_reg;

endmodule

`default_nettype wire

/* hw/rtl/dpf_ctrl.sv */
// Controller state machine sequencing one input transaction at a time.
`default_nettype none

module dpf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dpf_pkg::dpf_status_t  status,
    output dpf_pkg::dpf_cmd_t     cmd
);
    import dpf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ADDR   = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_GATHER = 9'b000001000,
        S_DRAIN  = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_DIVIDE = 9'b001000000,
        S_WBACK  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.emit_req ? S_ADDR : S_FINISH;
                end
            end
            S_ADDR:
            begin
                cmd.rd_center = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.repair ? S_GATHER : S_FINISH;
            end
            S_GATHER:
            begin
                cmd.gather = 1'b1;
                if (status.gather_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (status.k_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else
                    state_next = S_FINISH;
            end
            S_DIVIDE:
            begin
                if (status.div_done)
                    state_next = S_WBACK;
                else
                    cmd.div_step = 1'b1;
            end
            S_WBACK:
            begin
                cmd.write_back = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/dark_pixel_fill_3x3.sv */
// Top level of the 3x3 dark pixel fill block.
// Sequence: a transaction with no pixel out goes straight to the result register; a pixel passed
// through first has its center read from the store; a window with too few lit neighbors also does
// the 8 store reads of the gather; a repaired pixel then runs the divider, then write-back.
// One transaction is taken at a time; a new one is accepted only after the result register loads.
// Reset clears counters, control and registers to 1024x1024; the store is not cleared.
`default_nettype none

module dark_pixel_fill_3x3 (
    input  logic       clk,
    input  logic       rst_n,
    dpf_in_if.sink     pixels,
    dpf_out_if.source  results,
    dpf_cfg_if.sink    cfg
);
    import dpf_pkg::*;

    dpf_cmd_t    cmd;
    dpf_status_t status;
    logic        in_ready;

    assign pixels.ready = in_ready;

    dpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dpf_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  ({pixels.red_in, pixels.green_in, pixels.blue_in}),
        .flush   (pixels.flush),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg),
        .results (results)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.ready) |=> !pixels.ready)
        else $error("second transaction accepted while one is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!results.valid || results.ready))
        else $error("result register overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.out_valid) |->
            (results.red_out == '0 && results.green_out == '0 && results.blue_out == '0 &&
             results.out_column == '0 && results.out_row == '0 && !results.frame_end))
        else $error("empty result carries nonzero payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_back |-> $past(cmd.div_step || status.div_done))
        else $error("write-back without a finished divide");

endmodule

`default_nettype wire
